[src/csns_pkg.sv]
package csns_pkg;

  // Slot geometry.
  localparam int SLOT_BYTES = 32;
  localparam int SLOT_COUNT = 2;
  localparam int FILE_LIMIT = SLOT_BYTES * SLOT_COUNT;
  localparam int CNT_W      = $clog2(FILE_LIMIT + 1);
  localparam int OFF_W      = $clog2(SLOT_BYTES);

  // Byte offsets inside one slot.
  localparam logic [OFF_W-1:0] OFF_MAGIC     = OFF_W'(4);
  localparam logic [OFF_W-1:0] OFF_VERSION   = OFF_W'(5);
  localparam logic [OFF_W-1:0] OFF_SEQUENCE  = OFF_W'(8);
  localparam logic [OFF_W-1:0] OFF_TERM      = OFF_W'(16);
  localparam logic [OFF_W-1:0] OFF_VOTE      = OFF_W'(24);
  localparam logic [OFF_W-1:0] OFF_RESERVED  = OFF_W'(28);
  localparam logic [OFF_W-1:0] OFF_SLOT_LAST = OFF_W'(SLOT_BYTES - 1);

  // Configuration register file.
  localparam int REG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION = 1'b1;

  // Result codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_CORRUPT = 1'b1;

  // CRC32C, reflected form.
  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // One byte of the reflected CRC32C update.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[src/checked_slot_newest_selector_unit.sv]
// Reads a state file one byte per transfer and splits it into whole 32-byte
// slots; only the first SLOT_COUNT slots are examined and later bytes are
// ignored. A slot is valid when its magic and version bytes match the
// configured values and its little-endian CRC32C in bytes 0..3 matches the
// CRC32C of bytes 4..31. The valid slot with the highest sequence wins, the
// earlier one on a tie. The byte marked tlast produces one result: tuser is
// 0 (ok) with the chosen sequence, term and vote, or 1 (corrupt) with zeros.
// The block takes one byte every cycle while not stalled; a byte passes an
// input register and the per-byte CRC, capture and selection logic, and the
// result for a last byte is registered in the result register. Input stalls
// only while a finished result waits on the output and another last byte is
// queued behind it. Configuration writes belong between files.
module checked_slot_newest_selector_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [csns_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [csns_pkg::REG_W-1:0]    cfg_data_i,
  // Input byte stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tlast,   // last_byte
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [159:0]                  m_axis_tdata,   // [63:0] sequence_res,
                                                        // [127:64] term,
                                                        // [159:128] vote
  output logic                          m_axis_tuser    // status
);
  import csns_pkg::*;

  // Configuration registers.
  logic [REG_W-1:0] magic_q, version_q;

  // Input register.
  logic       in_valid_q, in_last_q;
  logic [7:0] in_byte_q;
  logic       advance;

  // File and slot state.
  logic [CNT_W-1:0] count_q, count_d;
  logic [31:0]      crc_q, crc_d;
  logic [3:0][7:0]  stored_q, stored_d;
  logic             hdr_ok_q, hdr_ok_d;
  logic [7:0][7:0]  seq_q, seq_d;
  logic [7:0][7:0]  term_q, term_d;
  logic [3:0][7:0]  vote_q, vote_d;
  logic             best_found_q, best_found_d;
  logic [63:0]      best_seq_q, best_seq_d;
  logic [63:0]      best_term_q, best_term_d;
  logic [31:0]      best_vote_q, best_vote_d;

  // Result register.
  logic         out_valid_q;
  logic         status_q;
  logic [159:0] out_data_q;

  logic [OFF_W-1:0] off;
  logic             in_range;
  logic             slot_valid;

  // The input register advances unless its last byte would overwrite a waiting result.
  assign advance       = in_valid_q & (~in_last_q | ~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  assign off      = count_q[OFF_W-1:0];
  assign in_range = (count_q < CNT_W'(FILE_LIMIT));

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      version_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAGIC:   magic_q   <= cfg_data_i;
        REG_VERSION: version_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Per-byte slot processing: capture, CRC, header check and slot selection.
  // Every captured byte is rewritten inside each slot, so only the CRC and the
  // header flag restart at the magic byte.
  always_comb begin
    count_d      = count_q;
    crc_d        = crc_q;
    stored_d     = stored_q;
    hdr_ok_d     = hdr_ok_q;
    seq_d        = seq_q;
    term_d       = term_q;
    vote_d       = vote_q;
    best_found_d = best_found_q;
    best_seq_d   = best_seq_q;
    best_term_d  = best_term_q;
    best_vote_d  = best_vote_q;
    slot_valid   = 1'b0;

    if (in_range) begin
      if (off < OFF_MAGIC) begin
        stored_d[off[1:0]] = in_byte_q;
      end else begin
        crc_d = crc32c_byte((off == OFF_MAGIC) ? CRC_INIT : crc_q, in_byte_q);
      end

      if (off == OFF_MAGIC) begin
        hdr_ok_d = (in_byte_q == magic_q);
      end else if (off == OFF_VERSION) begin
        hdr_ok_d = hdr_ok_q & (in_byte_q == version_q);
      end

      if (off >= OFF_SEQUENCE && off < OFF_TERM) begin
        seq_d[off[2:0]] = in_byte_q;
      end else if (off >= OFF_TERM && off < OFF_VOTE) begin
        term_d[off[2:0]] = in_byte_q;
      end else if (off >= OFF_VOTE && off < OFF_RESERVED) begin
        vote_d[off[1:0]] = in_byte_q;
      end

      // Closing byte of a slot: check it and keep it if it is newer.
      if (off == OFF_SLOT_LAST) begin
        slot_valid = hdr_ok_q && (stored_q == ~crc_d);
        if (slot_valid && (!best_found_q || seq_q > best_seq_q)) begin
          best_found_d = 1'b1;
          best_seq_d   = seq_q;
          best_term_d  = term_q;
          best_vote_d  = vote_q;
        end
      end

      count_d = count_q + CNT_W'(1);
    end
  end

  // File state; a last byte rewinds it for the next file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      best_found_q <= 1'b0;
    end else if (advance) begin
      count_q      <= in_last_q ? '0 : count_d;
      best_found_q <= in_last_q ? 1'b0 : best_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      crc_q       <= crc_d;
      stored_q    <= stored_d;
      hdr_ok_q    <= hdr_ok_d;
      seq_q       <= seq_d;
      term_q      <= term_d;
      vote_q      <= vote_d;
      best_seq_q  <= best_seq_d;
      best_term_q <= best_term_d;
      best_vote_q <= best_vote_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      if (best_found_d) begin
        status_q   <= STATUS_OK;
        out_data_q <= {best_vote_d, best_term_d, best_seq_d};
      end else begin
        status_q   <= STATUS_CORRUPT;
        out_data_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = status_q;

  // The byte counter saturates at the file limit.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FILE_LIMIT))
    else $error("byte counter ran past the file limit");

  // Input stalls only for a queued last byte behind a waiting result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && in_last_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a blocked result");

  // A processed last byte rewinds the file state.
  a_file_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> (count_q == '0 && !best_found_q))
    else $error("file state not cleared after last byte");

  // A result appears only from a processed last byte.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && in_last_q))
    else $error("result raised without a last byte");

endmodule
